>>> rtl/cpu_alu_with_flags_assert.svh
// Assertion macros shared by the cpu_alu_with_flags RTL.
// Expects a clock named aclk and an active-low reset named aresetn in scope.
`ifndef CPU_ALU_WITH_FLAGS_ASSERT_SVH
`define CPU_ALU_WITH_FLAGS_ASSERT_SVH

// Checked only outside reset.
`define CAF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every edge, reset included.
`define CAF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

>>> rtl/caf_pkg.sv
// Shared types, operation codes and flag positions for the ALU block.
// No dependencies.
`default_nettype none

package caf_pkg;

    localparam int OP_W    = 4;
    localparam int DATA_W  = 16;
    localparam int BYTE_W  = 8;
    localparam int FLAGS_W = 4;

    // Stream widths: fields packed from bit 0, padded to whole bytes.
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 24;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ADD8  = 4'd0;
    localparam logic [OP_W-1:0] OP_SUB8  = 4'd1;
    localparam logic [OP_W-1:0] OP_AND   = 4'd2;
    localparam logic [OP_W-1:0] OP_OR    = 4'd3;
    localparam logic [OP_W-1:0] OP_XOR   = 4'd4;
    localparam logic [OP_W-1:0] OP_CP    = 4'd5;
    localparam logic [OP_W-1:0] OP_INC8  = 4'd6;
    localparam logic [OP_W-1:0] OP_DEC8  = 4'd7;
    localparam logic [OP_W-1:0] OP_ADD16 = 4'd8;
    localparam logic [OP_W-1:0] OP_INC16 = 4'd9;
    localparam logic [OP_W-1:0] OP_DEC16 = 4'd10;
    localparam logic [OP_W-1:0] OP_CCF   = 4'd11;
    localparam logic [OP_W-1:0] OP_SCF   = 4'd12;

    // Flag bit positions
    localparam int FLAG_Z = 3;
    localparam int FLAG_N = 2;
    localparam int FLAG_H = 1;
    localparam int FLAG_C = 0;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [DATA_W-1:0]  first_operand;
        logic [DATA_W-1:0]  second_operand;
        logic [FLAGS_W-1:0] flags_in;
    } caf_item_t;

    typedef struct packed {
        logic [DATA_W-1:0]  result_value;
        logic [FLAGS_W-1:0] flags_out;
    } caf_result_t;

endpackage

`default_nettype wire

>>> rtl/cpu_alu_with_flags.sv
// Z80-style 8/16-bit ALU with Z N H C flags: one operation per beat, two register stages
// (input register, ALU logic, result register). An accepted beat waits in the input
// register and its result moves into the result register, which drives m_tdata, when it
// frees up. A new beat can be taken every cycle unless stalled; the pipeline holds two items,
// stalling from result side to input side when both stages are full and m_tready is low.
// Depends on caf_pkg, caf_alu and cpu_alu_with_flags_assert.svh.
`default_nettype none

module cpu_alu_with_flags
    import caf_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // input beat
    input  wire logic                  s_tvalid,
    output      logic                  s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // first_operand[15:0], second_operand[31:16],
                                                  // flags_in[35:32], zero pad
    input  wire logic [OP_W-1:0]       s_tuser,   // op[3:0]
    // result beat
    output      logic                  m_tvalid,
    input  wire logic                  m_tready,
    output      logic [M_TDATA_W-1:0]  m_tdata    // result_value[15:0], flags_out[19:16], zero pad
);

    logic        in_valid_reg;
    logic        in_valid_next;
    caf_item_t   in_item_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    caf_result_t out_res_reg;
    caf_result_t alu_res;
    logic        out_advance;
    logic        in_advance;

    // result register frees up when empty or taken this cycle
    assign out_advance = !out_valid_reg || m_tready;
    assign in_advance  = in_valid_reg && out_advance;
    assign s_tready    = !in_valid_reg || out_advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
        end
        out_valid_next = out_valid_reg;
        if (out_advance) begin
            out_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.op             <= s_tuser;
            in_item_reg.first_operand  <= s_tdata[15:0];
            in_item_reg.second_operand <= s_tdata[31:16];
            in_item_reg.flags_in       <= s_tdata[35:32];
        end
        if (in_advance) begin
            out_res_reg <= alu_res;
        end
    end

    caf_alu u_alu (
        .item (in_item_reg),
        .res  (alu_res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_res_reg.flags_out, out_res_reg.result_value};

`include "cpu_alu_with_flags_assert.svh"

    `CAF_ASSERT_ALWAYS(a_reset_empties, !aresetn |=> !m_tvalid && s_tready, "reset left pipeline busy")
    `CAF_ASSERT(a_accept_fills, s_tvalid && s_tready |=> in_valid_reg, "accepted beat not held")
    `CAF_ASSERT(a_full_stall, in_valid_reg && m_tvalid && !m_tready |-> !s_tready, "took beat while full")
    `CAF_ASSERT(a_result_load,
        in_advance |=> m_tvalid && m_tdata[15:0] == $past(alu_res.result_value)
            && m_tdata[19:16] == $past(alu_res.flags_out),
        "result mismatch")
    `CAF_ASSERT(a_sub_sets_n, in_valid_reg && (in_item_reg.op == OP_SUB8 || in_item_reg.op == OP_CP) |-> alu_res.flags_out[FLAG_N], "N clear on subtract")

endmodule

`default_nettype wire

>>> rtl/caf_alu.sv
// Combinational 8/16-bit ALU with Z N H C flag generation.
// Depends on caf_pkg.
`default_nettype none

module caf_alu
    import caf_pkg::*;
(
    input  caf_item_t   item,
    output caf_result_t res
);

    always_comb begin
        logic [BYTE_W-1:0]  a8;
        logic [BYTE_W-1:0]  b8;
        logic [BYTE_W:0]    sum9;
        logic [BYTE_W:0]    diff9;
        logic [4:0]         hsum5;
        logic [4:0]         hdiff5;
        logic [DATA_W:0]    sum17;
        logic [12:0]        hsum13;
        logic [BYTE_W-1:0]  r8;
        logic [FLAGS_W-1:0] fin;

        a8     = item.first_operand[BYTE_W-1:0];
        b8     = item.second_operand[BYTE_W-1:0];
        fin    = item.flags_in;
        sum9   = {1'b0, a8} + {1'b0, b8};
        diff9  = {1'b0, a8} - {1'b0, b8};
        hsum5  = {1'b0, a8[3:0]} + {1'b0, b8[3:0]};
        hdiff5 = {1'b0, a8[3:0]} - {1'b0, b8[3:0]};
        sum17  = {1'b0, item.first_operand} + {1'b0, item.second_operand};
        hsum13 = {1'b0, item.first_operand[11:0]} + {1'b0, item.second_operand[11:0]};
        r8     = '0;

        // Unused codes and flag-only ops pass the first operand through.
        res.result_value = item.first_operand;
        res.flags_out    = fin;

        case (item.op)
            OP_ADD8: begin
                r8 = sum9[BYTE_W-1:0];
                res.result_value = {8'd0, r8};
                res.flags_out = {(r8 == 8'd0), 1'b0, hsum5[4], sum9[BYTE_W]};
            end
            OP_SUB8, OP_CP: begin
                r8 = diff9[BYTE_W-1:0];
                if (item.op == OP_SUB8) begin
                    res.result_value = {8'd0, r8};
                end
                // borrow out of the top bit equals a < b
                res.flags_out = {(r8 == 8'd0), 1'b1, hdiff5[4], diff9[BYTE_W]};
            end
            OP_AND: begin
                r8 = a8 & b8;
                res.result_value = {8'd0, r8};
                res.flags_out = {(r8 == 8'd0), 1'b0, 1'b1, 1'b0};
            end
            OP_OR: begin
                r8 = a8 | b8;
                res.result_value = {8'd0, r8};
                res.flags_out = {(r8 == 8'd0), 3'b000};
            end
            OP_XOR: begin
                r8 = a8 ^ b8;
                res.result_value = {8'd0, r8};
                res.flags_out = {(r8 == 8'd0), 3'b000};
            end
            OP_INC8: begin
                r8 = a8 + 8'd1;
                res.result_value = {8'd0, r8};
                res.flags_out = {(r8 == 8'd0), 1'b0, (a8[3:0] == 4'hF), fin[FLAG_C]};
            end
            OP_DEC8: begin
                r8 = a8 - 8'd1;
                res.result_value = {8'd0, r8};
                res.flags_out = {(r8 == 8'd0), 1'b1, (a8[3:0] == 4'h0), fin[FLAG_C]};
            end
            OP_ADD16: begin
                res.result_value = sum17[DATA_W-1:0];
                res.flags_out = {fin[FLAG_Z], 1'b0, hsum13[12], sum17[DATA_W]};
            end
            OP_INC16: begin
                res.result_value = item.first_operand + 16'd1;
            end
            OP_DEC16: begin
                res.result_value = item.first_operand - 16'd1;
            end
            OP_CCF: begin
                res.flags_out = {fin[FLAG_Z], 1'b0, 1'b0, ~fin[FLAG_C]};
            end
            OP_SCF: begin
                res.flags_out = {fin[FLAG_Z], 1'b0, 1'b0, 1'b1};
            end
            default: begin
                res.result_value = item.first_operand;
                res.flags_out    = fin;
            end
        endcase
    end

endmodule

`default_nettype wire
